### sv/htw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htw_pkg
// Types and codes shared by the timer wheel controller, datapath and top.
// ----------------------------------------------------------------------------
package htw_pkg;

  localparam int CAPACITY = 8;
  localparam int BUCKETS  = 4;

  localparam logic [1:0] OP_SCHEDULE = 2'd0;
  localparam logic [1:0] OP_CANCEL   = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;
  localparam logic [1:0] OP_STOP     = 2'd3;

  localparam logic [2:0] KIND_SCHED   = 3'd0;
  localparam logic [2:0] KIND_CANCEL  = 3'd1;
  localparam logic [2:0] KIND_EXPIRY  = 3'd2;
  localparam logic [2:0] KIND_EMPTY   = 3'd3;
  localparam logic [2:0] KIND_REFUSED = 3'd4;
  localparam logic [2:0] KIND_STOP    = 3'd5;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_CLOSED    = 3'd1;
  localparam logic [2:0] ERR_NOT_FUT   = 3'd2;
  localparam logic [2:0] ERR_FULL      = 3'd3;
  localparam logic [2:0] ERR_IDS_EXHST = 3'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] deadline;
    logic [31:0] token;
    logic [2:0]  slot_index;
    logic [63:0] handle_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  error;
    logic        accepted;
    logic [2:0]  slot_out;
    logic [63:0] id_out;
    logic [31:0] token_out;
    logic [63:0] deadline_out;
    logic [63:0] emit_tick;
    logic [3:0]  cancelled_count;
    logic [3:0]  pending_count;
    logic        last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;     // capture input transaction
    logic do_sched;    // decide and perform schedule, emit reply
    logic do_cancel;   // decide and perform cancel, emit reply
    logic do_stop;     // close and clear, emit reply
    logic tick_start;  // check, advance time, load walk pointer
    logic walk_step;   // visit one list slot
    logic tick_end;    // emit held final expiry, or empty tick if nothing was due
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] opcode;
    logic       refused;   // tick start refused
    logic       walk_done; // walk pointer exhausted or slot limit reached
    logic       emit;      // datapath put a result this cycle
  } dp_stat_t;

endpackage
`default_nettype wire

### sv/htw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htw_ctrl
// Sequencer: take one transaction, step the datapath, wait on output stalls.
// ----------------------------------------------------------------------------
module htw_ctrl import htw_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire logic     out_busy,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_WALK  = 5'b00100,
    S_END   = 5'b01000,
    S_WAIT  = 5'b10000
  } state_t;

  state_t state, state_next;

  assign in_stall = rst || (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_busy) begin
          unique case (stat.opcode)
            OP_SCHEDULE: begin cmd.do_sched = 1'b1;  state_next = S_IDLE; end
            OP_CANCEL:   begin cmd.do_cancel = 1'b1; state_next = S_IDLE; end
            OP_STOP:     begin cmd.do_stop = 1'b1;   state_next = S_IDLE; end
            default: begin
              cmd.tick_start = 1'b1;
              state_next = stat.refused ? S_IDLE : S_WALK;
            end
          endcase
        end
      end
      S_WALK: begin
        if (stat.walk_done) begin
          state_next = S_END;
        end else if (!out_busy) begin
          cmd.walk_step = 1'b1;
        end
      end
      S_END: begin
        if (!out_busy) begin
          cmd.tick_end = 1'b1;
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

### sv/htw_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htw_dp
// Slot pool, bucket lists, time and id counters, and the output register.
// ----------------------------------------------------------------------------
module htw_dp import htw_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire in_item_t  in_data,
  input  wire logic      cfg_valid,
  input  wire logic [63:0] cfg_data,
  input  wire dp_cmd_t   cmd,
  output dp_stat_t       stat,
  input  wire logic      out_stall,
  output logic           out_valid,
  output out_item_t      out_data,
  output logic           out_busy
);

  localparam int IW = $clog2(CAPACITY + 1);
  localparam int SW = $clog2(CAPACITY);
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] NONE = IW'(CAPACITY);
  localparam logic [63:0] TMAX = '1;

  logic [63:0]   slot_deadline [CAPACITY];
  logic [31:0]   slot_token    [CAPACITY];
  logic [63:0]   slot_id       [CAPACITY];
  logic [IW-1:0] slot_prev     [CAPACITY];
  logic [IW-1:0] slot_next     [CAPACITY];
  logic [CAPACITY-1:0] slot_active;
  logic [IW-1:0] bucket_head   [BUCKETS];
  logic [IW-1:0] free_head;
  logic [CW-1:0] pending;
  logic [63:0]   now_tick;
  logic [63:0]   next_id;
  logic          closed;
  in_item_t      req;
  logic [IW-1:0] cur;
  logic [CW-1:0] guard;
  logic          any_due;
  out_item_t     held;

  function automatic logic [BW-1:0] bucket_of(input logic [63:0] t);
    logic [63:0] r;
    r = t % 64'(BUCKETS);
    return r[BW-1:0];
  endfunction

  logic [IW-1:0] fs;
  logic [BW-1:0] sb;
  logic [IW-1:0] sched_nx;
  logic [2:0]    sched_err;
  logic          cancel_ok;
  logic [SW-1:0] cidx;
  logic [IW-1:0] ws;
  logic          wdue;
  logic [IW-1:0] rel_s, rel_p, rel_n;
  logic          rel_en;
  logic [63:0]   now_inc;
  logic          out_load;
  out_item_t     res;
  out_item_t     exp_res;

  assign fs = free_head;
  assign sb = bucket_of(req.deadline);
  assign sched_nx = bucket_head[sb];
  assign cidx = req.slot_index;
  assign ws = cur;
  assign now_inc = now_tick + 64'd1;

  always_comb begin
    if (closed)                          sched_err = ERR_CLOSED;
    else if (req.deadline <= now_tick)   sched_err = ERR_NOT_FUT;
    else if (free_head >= NONE)          sched_err = ERR_FULL;
    else if (next_id == TMAX)            sched_err = ERR_IDS_EXHST;
    else                                 sched_err = ERR_NONE;
  end

  assign cancel_ok = slot_active[cidx] && (slot_id[cidx] == req.handle_id);
  assign wdue = (ws < NONE) && (slot_deadline[ws[SW-1:0]] <= now_tick);

  always_comb begin
    rel_en = 1'b0;
    rel_s = IW'(cidx);
    if (cmd.do_cancel && cancel_ok) begin
      rel_en = 1'b1;
    end else if (cmd.walk_step && wdue) begin
      rel_en = 1'b1;
      rel_s = ws;
    end
  end
  assign rel_p = slot_prev[rel_s[SW-1:0]];
  assign rel_n = slot_next[rel_s[SW-1:0]];

  assign out_busy = out_valid && out_stall;
  assign stat.opcode = req.opcode;
  assign stat.refused = closed || (now_tick == TMAX);
  assign stat.walk_done = (cur >= NONE) || (guard >= CW'(CAPACITY));
  assign stat.emit = out_load;

  always_comb begin
    exp_res = '0;
    exp_res.kind = KIND_EXPIRY;
    exp_res.token_out = slot_token[ws[SW-1:0]];
    exp_res.deadline_out = slot_deadline[ws[SW-1:0]];
    exp_res.emit_tick = now_tick;
    exp_res.pending_count = 4'(pending - CW'(1));
  end

  always_comb begin
    res = '0;
    res.last = 1'b1;
    res.pending_count = 4'(pending);
    out_load = 1'b0;
    if (cmd.do_sched) begin
      out_load = 1'b1;
      res.kind = KIND_SCHED;
      res.error = sched_err;
      if (sched_err == ERR_NONE) begin
        res.accepted = 1'b1;
        res.slot_out = 3'(fs);
        res.id_out = next_id;
        res.pending_count = 4'(pending + CW'(1));
      end
    end else if (cmd.do_cancel) begin
      out_load = 1'b1;
      res.kind = KIND_CANCEL;
      res.accepted = cancel_ok;
      if (cancel_ok) res.pending_count = 4'(pending - CW'(1));
    end else if (cmd.do_stop) begin
      out_load = 1'b1;
      res.kind = KIND_STOP;
      res.cancelled_count = 4'(pending);
      res.pending_count = '0;
    end else if (cmd.tick_start && stat.refused) begin
      out_load = 1'b1;
      res.kind = KIND_REFUSED;
    end else if (cmd.walk_step && wdue && any_due) begin
      out_load = 1'b1;
      res = held;
    end else if (cmd.tick_end) begin
      out_load = 1'b1;
      if (any_due) begin
        res = held;
        res.last = 1'b1;
      end else begin
        res.kind = KIND_EMPTY;
        res.emit_tick = now_tick;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_data <= res;
    end
  end

  // Hold each expiry until the walk shows whether it is the final one.
  always_ff @(posedge clk) begin
    if (cmd.load_in) req <= in_data;
    if (cmd.tick_start) begin
      cur <= bucket_head[bucket_of(now_inc)];
      guard <= '0;
      any_due <= 1'b0;
    end else if (cmd.walk_step) begin
      cur <= slot_next[ws[SW-1:0]];
      guard <= guard + CW'(1);
      if (wdue) begin
        any_due <= 1'b1;
        held <= exp_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.do_stop) begin
      for (int i = 0; i < CAPACITY; i++) begin
        slot_next[i] <= IW'(i + 1);
        if (rst) begin
          slot_prev[i] <= NONE;
          slot_deadline[i] <= '0;
          slot_token[i] <= '0;
          slot_id[i] <= '0;
        end
      end
      for (int b = 0; b < BUCKETS; b++) bucket_head[b] <= NONE;
      slot_active <= '0;
      free_head <= '0;
      pending <= '0;
      if (rst) begin
        now_tick <= '0;
        next_id <= 64'd1;
        closed <= 1'b0;
      end else begin
        closed <= 1'b1;
      end
    end else begin
      if (cfg_valid) now_tick <= cfg_data;
      if (cmd.do_sched && sched_err == ERR_NONE) begin
        free_head <= slot_next[fs[SW-1:0]];
        slot_deadline[fs[SW-1:0]] <= req.deadline;
        slot_token[fs[SW-1:0]] <= req.token;
        slot_id[fs[SW-1:0]] <= next_id;
        next_id <= next_id + 64'd1;
        slot_active[fs[SW-1:0]] <= 1'b1;
        slot_prev[fs[SW-1:0]] <= NONE;
        slot_next[fs[SW-1:0]] <= sched_nx;
        if (sched_nx < NONE) slot_prev[sched_nx[SW-1:0]] <= fs;
        bucket_head[sb] <= fs;
        pending <= pending + CW'(1);
      end
      if (cmd.tick_start && !stat.refused) now_tick <= now_inc;
      if (rel_en) begin
        if (rel_p >= NONE) bucket_head[bucket_of(slot_deadline[rel_s[SW-1:0]])] <= rel_n;
        else slot_next[rel_p[SW-1:0]] <= rel_n;
        if (rel_n < NONE) slot_prev[rel_n[SW-1:0]] <= rel_p;
        slot_active[rel_s[SW-1:0]] <= 1'b0;
        slot_next[rel_s[SW-1:0]] <= free_head;
        free_head <= rel_s;
        if (pending > '0) pending <= pending - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

### sv/hashed_timer_wheel_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hashed_timer_wheel_top
// Hashed timer wheel with a fixed slot pool and per-bucket linked lists.
//
// channel | handshake          | payload
// in      | in_valid/in_stall  | in_data (in_item_t)
// out     | out_valid/out_stall| out_data (out_item_t)
// cfg     | cfg_valid/cfg_ready| cfg_data (start_tick)
//
// Schedule, cancel, stop and a refused tick each give one result.
// A tick walks one bucket list, visiting at most CAPACITY slots.
// Synchronous reset restores the whole pool at once.
// Output stalls hold the sequencer before each result is loaded.
// ----------------------------------------------------------------------------
module hashed_timer_wheel_top import htw_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [63:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     out_busy;

  assign cfg_ready = !rst;

  htw_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_busy(out_busy), .stat(stat), .cmd(cmd)
  );

  htw_dp u_dp (
    .clk(clk), .rst(rst), .in_data(in_data), .cfg_valid(cfg_valid),
    .cfg_data(cfg_data), .cmd(cmd), .stat(stat), .out_stall(out_stall),
    .out_valid(out_valid), .out_data(out_data), .out_busy(out_busy)
  );

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_in, cmd.do_sched, cmd.do_cancel, cmd.do_stop,
              cmd.tick_start, cmd.walk_step, cmd.tick_end}))
    else $error("more than one datapath command");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    stat.emit |-> !(out_valid && out_stall))
    else $error("result loaded over a stalled result");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |=> in_stall)
    else $error("sequencer did not leave idle");

endmodule
`default_nettype wire

### tb/sv/hashed_timer_wheel_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_timer_wheel_top_tb
// Self-checking bench for the hashed timer wheel. Schedules, cancels, ticks
// and stops go through the input channel, with random gaps in some tests. A
// local wheel predictor computes the replies and expiry events, and a checker
// compares every output transaction field by field against them in order.
// ----------------------------------------------------------------------------
module hashed_timer_wheel_top_tb;
  import htw_pkg::*;

  localparam int CAP = 8;
  localparam logic [3:0] NIL = 4'd8;
  localparam logic [63:0] TMAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int WATCHDOG = 5000;

  typedef struct packed {
    logic [2:0]  slot;
    logic [63:0] id;
  } handle_t;

  logic      clk = 0;
  logic      rst = 1;
  logic      in_valid = 0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 0;
  out_item_t out_data;
  logic      cfg_valid = 0;
  logic      cfg_ready;
  logic [63:0] cfg_data = '0;

  hashed_timer_wheel_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // wheel state
  logic [63:0] w_deadline [CAP];
  logic [31:0] w_token [CAP];
  logic [63:0] w_id [CAP];
  logic [3:0]  w_prev [CAP];
  logic [3:0]  w_next [CAP];
  logic        w_active [CAP];
  logic [3:0]  w_head [4];
  logic [3:0]  w_free;
  logic [3:0]  w_pending;
  logic [63:0] w_now;
  logic [63:0] w_next_id;
  logic        w_closed;

  out_item_t   due_results[$];
  handle_t     live_handles[$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_expiries = 0;
  bit idle_en = 0;
  bit hold_req = 0;
  int quiet = 0;

  task automatic wheel_clear();
    for (int i = 0; i < CAP; i++) begin
      w_active[i] = 0;
      w_next[i] = 4'(i + 1);
    end
    for (int b = 0; b < 4; b++) w_head[b] = NIL;
    w_free = 0;
    w_pending = 0;
  endtask

  task automatic wheel_reset();
    for (int i = 0; i < CAP; i++) begin
      w_deadline[i] = '0;
      w_token[i] = '0;
      w_id[i] = '0;
      w_prev[i] = NIL;
    end
    wheel_clear();
    w_now = '0;
    w_next_id = 64'd1;
    w_closed = 0;
  endtask

  task automatic wheel_release(input logic [3:0] s);
    logic [3:0] p;
    logic [3:0] n;
    p = w_prev[s];
    n = w_next[s];
    if (p >= NIL) w_head[w_deadline[s][1:0]] = n;
    else w_next[p] = n;
    if (n < NIL) w_prev[n] = p;
    w_active[s] = 0;
    w_next[s] = w_free;
    w_free = s;
    if (w_pending > 0) w_pending--;
  endtask

  task automatic wheel_apply(input in_item_t it);
    out_item_t r;
    logic [2:0] err;
    logic [3:0] s;
    logic [3:0] cur;
    logic [3:0] nx;
    logic [3:0] was;
    int k;
    r = '0;
    r.last = 1;
    case (it.opcode)
      OP_SCHEDULE: begin
        r.kind = KIND_SCHED;
        err = ERR_NONE;
        if (w_closed) err = ERR_CLOSED;
        else if (it.deadline <= w_now) err = ERR_NOT_FUT;
        else if (w_free >= NIL) err = ERR_FULL;
        else if (w_next_id == TMAX) err = ERR_IDS_EXHST;
        if (err != ERR_NONE) begin
          r.error = err;
        end else begin
          s = w_free;
          w_free = w_next[s];
          w_deadline[s] = it.deadline;
          w_token[s] = it.token;
          w_id[s] = w_next_id;
          w_next_id++;
          w_active[s] = 1;
          w_prev[s] = NIL;
          w_next[s] = w_head[it.deadline[1:0]];
          if (w_next[s] < NIL) w_prev[w_next[s]] = s;
          w_head[it.deadline[1:0]] = s;
          w_pending++;
          r.accepted = 1;
          r.slot_out = s[2:0];
          r.id_out = w_id[s];
          live_handles.push_back('{slot: s[2:0], id: w_id[s]});
        end
        r.pending_count = w_pending;
        due_results.push_back(r);
      end
      OP_CANCEL: begin
        r.kind = KIND_CANCEL;
        if (w_active[it.slot_index] && w_id[it.slot_index] == it.handle_id) begin
          wheel_release({1'b0, it.slot_index});
          r.accepted = 1;
        end
        r.pending_count = w_pending;
        due_results.push_back(r);
      end
      OP_TICK: begin
        if (w_closed || w_now == TMAX) begin
          r.kind = KIND_REFUSED;
          r.pending_count = w_pending;
          due_results.push_back(r);
        end else begin
          w_now++;
          cur = w_head[w_now[1:0]];
          k = 0;
          for (int g = 0; g < CAP && cur < NIL; g++) begin
            nx = w_next[cur];
            if (w_deadline[cur] <= w_now) begin
              r = '0;
              r.kind = KIND_EXPIRY;
              r.token_out = w_token[cur];
              r.deadline_out = w_deadline[cur];
              r.emit_tick = w_now;
              wheel_release(cur);
              r.pending_count = w_pending;
              due_results.push_back(r);
              k++;
            end
            cur = nx;
          end
          if (k == 0) begin
            r = '0;
            r.kind = KIND_EMPTY;
            r.emit_tick = w_now;
            r.pending_count = w_pending;
            r.last = 1;
            due_results.push_back(r);
          end else begin
            due_results[$].last = 1;
          end
        end
      end
      default: begin
        was = w_pending;
        w_closed = 1;
        wheel_clear();
        r.kind = KIND_STOP;
        r.cancelled_count = was;
        r.pending_count = w_pending;
        due_results.push_back(r);
      end
    endcase
  endtask

  // output checker
  task automatic cmp_field(input string f, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      $error("%s expected %0h actual %0h", f, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (due_results.size() == 0) begin
        $error("unexpected result kind %0d", out_data.kind);
        errors++;
      end else begin
        e = due_results.pop_front();
        if (e.kind == KIND_EXPIRY) n_expiries++;
        cmp_field("kind", e.kind, out_data.kind);
        cmp_field("error", e.error, out_data.error);
        cmp_field("accepted", e.accepted, out_data.accepted);
        cmp_field("slot_out", e.slot_out, out_data.slot_out);
        cmp_field("id_out", e.id_out, out_data.id_out);
        cmp_field("token_out", e.token_out, out_data.token_out);
        cmp_field("deadline_out", e.deadline_out, out_data.deadline_out);
        cmp_field("emit_tick", e.emit_tick, out_data.emit_tick);
        cmp_field("cancelled_count", e.cancelled_count, out_data.cancelled_count);
        cmp_field("pending_count", e.pending_count, out_data.pending_count);
        cmp_field("last", e.last, out_data.last);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else if (!rst)
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG);
      $display("FAIL hashed_timer_wheel_top");
      $finish;
    end
  end

  // receiver stalls
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1;
        repeat (300) @(posedge clk);
        hold_req = 0;
        out_stall <= 0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  task automatic send_item(input in_item_t it);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (!(in_valid && !in_stall));
    wheel_apply(it);
    n_items++;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_start_tick(input logic [63:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    w_now = v;
    @(posedge clk);
  endtask

  function automatic in_item_t make_item(input logic [1:0] op, input logic [63:0] dl,
                                         input logic [31:0] tok, input logic [2:0] sl,
                                         input logic [63:0] hid);
    in_item_t it;
    it.opcode = op;
    it.deadline = dl;
    it.token = tok;
    it.slot_index = sl;
    it.handle_id = hid;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int pick;
    handle_t h;
    it = make_item(OP_TICK, rand64(), $urandom, 3'($urandom), rand64());
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      it.opcode = OP_SCHEDULE;
      pick = $urandom_range(0, 99);
      if (pick < 75) it.deadline = (w_now > TMAX - 12) ? TMAX : w_now + $urandom_range(1, 12);
      else if (pick < 88) it.deadline = w_now - $urandom_range(0, 3);
    end else if (pick < 65) begin
      it.opcode = OP_CANCEL;
      if (live_handles.size() != 0 && $urandom_range(0, 9) < 7) begin
        h = live_handles[$urandom_range(0, live_handles.size() - 1)];
        it.slot_index = h.slot;
        it.handle_id = h.id;
      end
    end
    return it;
  endfunction

  task automatic test_directed();
    write_start_tick(64'd5);
    send_item(make_item(OP_SCHEDULE, 64'd5, 32'h1, 0, 0));
    send_item(make_item(OP_SCHEDULE, 64'd0, 32'h2, 0, 0));
    send_item(make_item(OP_SCHEDULE, 64'd6, 32'hFFFF_FFFF, 0, 0));
    send_item(make_item(OP_SCHEDULE, 64'd6, 32'h0, 0, 0));
    send_item(make_item(OP_SCHEDULE, 64'd10, 32'hA5A5_5A5A, 0, 0));
    send_item(make_item(OP_SCHEDULE, 64'd7, 32'h7, 0, 0));
    send_item(make_item(OP_SCHEDULE, TMAX, 32'h8000_0000, 0, 0));
    send_item(make_item(OP_SCHEDULE, 64'd8, 32'h8, 0, 0));
    send_item(make_item(OP_SCHEDULE, 64'd9, 32'h9, 0, 0));
    send_item(make_item(OP_SCHEDULE, 64'd12, 32'hC, 0, 0));
    send_item(make_item(OP_SCHEDULE, 64'd11, 32'hB, 0, 0));
    send_item(make_item(OP_CANCEL, 0, 0, 3'd3, 64'd4));
    send_item(make_item(OP_CANCEL, 0, 0, 3'd3, 64'd4));
    send_item(make_item(OP_CANCEL, 0, 0, 3'd5, 64'd99));
    send_item(make_item(OP_CANCEL, 0, 0, 3'd7, TMAX));
    repeat (8) send_item(make_item(OP_TICK, 0, 0, 0, 0));
    drain();
  endtask

  task automatic test_backpressure();
    hold_req = 1;
    repeat (20) send_item(random_item());
    drain();
    while (hold_req) @(posedge clk);
  endtask

  task automatic test_random();
    idle_en = 1;
    for (int i = 0; i < 90; i++) begin
      send_item(random_item());
      if (i == 45) begin
        drain();
        write_start_tick(64'd1000 + $urandom_range(0, 3));
      end
    end
    drain();
  endtask

  task automatic test_time_limit();
    write_start_tick(TMAX - 3);
    send_item(make_item(OP_SCHEDULE, TMAX, 32'h1234_5678, 0, 0));
    send_item(make_item(OP_SCHEDULE, TMAX - 1, 32'h8765_4321, 0, 0));
    send_item(make_item(OP_SCHEDULE, TMAX - 3, 32'h0, 0, 0));
    repeat (5) send_item(make_item(OP_TICK, 0, 0, 0, 0));
    drain();
    write_start_tick(64'd0);
  endtask

  task automatic test_quiet_tail();
    idle_en = 0;
    repeat (20) send_item(random_item());
    drain();
  endtask

  task automatic test_stop();
    send_item(make_item(OP_SCHEDULE, w_now + 3, 32'h3, 0, 0));
    send_item(make_item(OP_SCHEDULE, w_now + 4, 32'h4, 0, 0));
    send_item(make_item(OP_STOP, 0, 0, 0, 0));
    send_item(make_item(OP_STOP, 0, 0, 0, 0));
    send_item(make_item(OP_SCHEDULE, w_now + 5, 32'h5, 0, 0));
    send_item(make_item(OP_TICK, 0, 0, 0, 0));
    send_item(make_item(OP_CANCEL, 0, 0, 3'd0, 64'd1));
    drain();
  endtask

  initial begin
    wheel_reset();
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    test_time_limit();
    test_quiet_tail();
    test_stop();
    $display("covered %0d requests, %0d results (%0d expiries), incl. full pool,",
             n_items, n_results, n_expiries);
    $display("time-limit refusals, a long output hold-off and stop of the wheel");
    if (errors == 0 && due_results.size() == 0) begin
      $display("PASS hashed_timer_wheel_top");
    end else begin
      $display("FAIL hashed_timer_wheel_top");
    end
    $finish;
  end

endmodule
